// ===== src/evd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evd_pkg
// Shared types and codes for the exact vertex dedup table.
// ----------------------------------------------------------------------------
package evd_pkg;

  localparam int COORD_W = 64;
  localparam int INDEX_W = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 11;

  localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic               mesh_start;
    logic [COORD_W-1:0] coord_x_bits;
    logic [COORD_W-1:0] coord_y_bits;
    logic [COORD_W-1:0] coord_z_bits;
  } evd_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  vertex_index;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  unique_count;
  } evd_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } evd_key_t;

endpackage

// ===== src/exact_vertex_dedup_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exact_vertex_dedup_table_unit
// Exact vertex welding: look up a 192-bit key among the stored unique
// vertices and return its index, inserting a miss at the next free slot if any.
// ----------------------------------------------------------------------------
//  channel | ports                      | transfer when
//  --------+----------------------------+------------------------------
//  input   | start, busy, in_item       | start && !busy
//  result  | out_valid, out_item        | out_valid (one cycle, no stall)
//
//  The key RAM read port scans one stored entry per cycle; the registered
//  read, the registered compare and the result register follow it. A hit on
//  index i raises the result strobe once compare i has passed the compare
//  register. A miss against N stored keys raises it once the last compare
//  has drained, or straight from the scan state on an empty table.
//  busy stays high from accept until the result strobe; the next item can
//  be accepted in the cycle the result is shown.
//  Reset empties the table (count to zero); key storage is not cleared.
//  The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module exact_vertex_dedup_table_unit #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  evd_pkg::evd_in_t   in_item,
  output logic               out_valid,
  output evd_pkg::evd_out_t  out_item
);
  import evd_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic          state_r, state_nxt;
  evd_key_t      key_r, key_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [IW-1:0] rd_idx_r;
  logic          out_valid_r, out_valid_nxt;
  evd_out_t      out_item_r, out_item_nxt;

  logic          accept;
  logic          issuing;
  logic          finish_miss;
  logic          finish;
  logic          table_full;
  logic          wr_en;
  logic [IW-1:0] rd_addr;
  evd_key_t      rd_entry;
  logic          m_pend;
  logic          m_hit;
  logic [IW-1:0] m_hit_idx;
  logic [31:0]   idx_ext;
  logic [31:0]   cnt_ext;
  logic [31:0]   cnt_inc_ext;

  assign accept  = start && (state_r == ST_IDLE);
  assign issuing = (state_r == ST_SCAN) && (issue_r < count_r);
  assign rd_addr = issue_r[IW-1:0];

  // Miss once every stored entry has been read and compared.
  assign finish_miss = (state_r == ST_SCAN) && !issuing && !rd_vld_r && !m_pend;
  assign finish      = m_hit || finish_miss;
  assign table_full  = (count_r == MAX_CNT);
  assign wr_en       = finish_miss && !table_full;

  assign idx_ext     = 32'(m_hit_idx);
  assign cnt_ext     = 32'(count_r);
  assign cnt_inc_ext = 32'(count_r) + 32'd1;

  evd_key_ram #(
    .DEPTH (MAX_VERTICES),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IW-1:0]),
    .wr_data (key_r),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  evd_key_match #(
    .IW (IW)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (finish || (state_r != ST_SCAN)),
    .probe_vld (rd_vld_r),
    .probe_idx (rd_idx_r),
    .entry     (rd_entry),
    .key       (key_r),
    .pend      (m_pend),
    .hit       (m_hit),
    .hit_idx   (m_hit_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    rd_vld_nxt    = issuing && !finish;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Capture the key; a mesh start empties the table first.
          key_nxt.x = in_item.coord_x_bits;
          key_nxt.y = in_item.coord_y_bits;
          key_nxt.z = in_item.coord_z_bits;
          if (in_item.mesh_start) begin
            count_nxt = '0;
          end
          issue_nxt = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issuing) begin
          issue_nxt = issue_r + CW'(1);
        end
        priority if (m_hit) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.vertex_index = idx_ext[INDEX_W-1:0];
          out_item_nxt.status       = STATUS_FOUND;
          out_item_nxt.unique_count = cnt_ext[COUNT_W-1:0];
          state_nxt                 = ST_IDLE;
        end else if (finish_miss && !table_full) begin
          // Store at the next free index; insertion order is the index.
          out_valid_nxt             = 1'b1;
          out_item_nxt.vertex_index = cnt_ext[INDEX_W-1:0];
          out_item_nxt.status       = STATUS_INSERTED;
          out_item_nxt.unique_count = cnt_inc_ext[COUNT_W-1:0];
          count_nxt                 = count_r + CW'(1);
          state_nxt                 = ST_IDLE;
        end else if (finish_miss) begin
          // Table full: drop the key, report index zero.
          out_valid_nxt             = 1'b1;
          out_item_nxt.vertex_index = '0;
          out_item_nxt.status       = STATUS_FULL;
          out_item_nxt.unique_count = cnt_ext[COUNT_W-1:0];
          state_nxt                 = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    rd_idx_r   <= rd_addr;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== src/evd_key_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evd_key_ram
// Single write, single read key store with registered read data.
// ----------------------------------------------------------------------------
module evd_key_ram #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  evd_pkg::evd_key_t wr_data,
  input  logic [AW-1:0]     rd_addr,
  output evd_pkg::evd_key_t rd_data
);
  import evd_pkg::*;

  evd_key_t mem [DEPTH];
  evd_key_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/evd_key_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evd_key_match
// Registered exact compare of one stored key against the probe key.
// ----------------------------------------------------------------------------
module evd_key_match #(
  parameter int IW = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              flush,
  input  logic              probe_vld,
  input  logic [IW-1:0]     probe_idx,
  input  evd_pkg::evd_key_t entry,
  input  evd_pkg::evd_key_t key,
  output logic              pend,
  output logic              hit,
  output logic [IW-1:0]     hit_idx
);
  import evd_pkg::*;

  logic          m_vld_r;
  logic          eq_r;
  logic [IW-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= probe_vld && !flush;
    end
    eq_r  <= (entry == key);
    idx_r <= probe_idx;
  end

  assign pend    = m_vld_r;
  assign hit     = m_vld_r && eq_r;
  assign hit_idx = idx_r;

endmodule

// ===== src/evd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evd_checker
// Port-level checks for the exact vertex dedup table, bound to the top.
// ----------------------------------------------------------------------------
module evd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input evd_pkg::evd_out_t out_item
);
  import evd_pkg::*;

  // An accepted transfer always leaves the block busy after the accepting edge.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // Each item finishes with exactly one result strobe as busy drops.
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("busy dropped without a result");

  // Results are never back to back: a scan lies between them.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == STATUS_FOUND ||
                   out_item.status == STATUS_INSERTED ||
                   out_item.status == STATUS_FULL))
    else $error("undefined status code");

  a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == STATUS_FULL) |-> (out_item.vertex_index == '0))
    else $error("full status with nonzero index");

endmodule

bind exact_vertex_dedup_table_unit evd_checker u_evd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ===== dv/exact_vertex_dedup_table_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exact_vertex_dedup_table_unit_test
// Self-checking bench for the exact vertex dedup table. A directed table of
// vertices (bit-pattern edge cases, signed zeros, NaNs, mesh restarts) runs
// first, then random meshes built as triangles with shared and near-miss
// vertices, plus one mesh that fills the table to capacity and probes it
// while full. Each result is checked against a typed row expectation or a
// behavioral weld table kept in the bench.
// ----------------------------------------------------------------------------
module exact_vertex_dedup_table_unit_test;
  import evd_pkg::*;

  localparam int TABLE_DEPTH    = 1024;
  localparam int TOTAL_ITEMS    = 1550;
  localparam int SMALL_PHASE    = 170;           // items before the big fill
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int TAIL_CYCLES    = TABLE_DEPTH + 16;
  localparam int MAX_REPORTS    = 10;

  // Coordinate bit patterns worth naming
  localparam logic [63:0] PAT_ZERO  = 64'h0000_0000_0000_0000;
  localparam logic [63:0] PAT_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PAT_NZERO = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PAT_INF   = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] PAT_NINF  = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] PAT_QNAN  = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] PAT_ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] PAT_ALT_5 = 64'h5555_5555_5555_5555;

  typedef struct {
    bit       mesh_start;
    evd_key_t key;
    bit       typed;
    evd_out_t want;
  } weld_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  evd_in_t  in_item;
  logic     out_valid;
  evd_out_t out_item;

  // Bench copy of the weld table
  evd_key_t    welded_keys [TABLE_DEPTH];
  int unsigned welded_count;

  evd_out_t  pending_welds[$];
  weld_row_t directed_rows[$];
  int        vertices_sent;
  int        mismatches;
  int        quiet_cycles;
  bit        no_idle;

  exact_vertex_dedup_table_unit #(
    .MAX_VERTICES(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Weld prediction: clear on mesh start, scan the live entries for an exact
  // 192-bit match, else append at the next free slot or report full.
  // --------------------------------------------------------------------------
  function automatic evd_out_t weld_lookup(evd_in_t v);
    evd_key_t    k;
    evd_out_t    r;
    int unsigned i;
    bit          hit;
    k.x = v.coord_x_bits;
    k.y = v.coord_y_bits;
    k.z = v.coord_z_bits;
    if (v.mesh_start) welded_count = 0;
    hit = 1'b0;
    r.vertex_index = '0;
    r.status = STATUS_FULL;
    for (i = 0; i < welded_count && !hit; i++) begin
      if (welded_keys[i] == k) begin
        hit = 1'b1;
        r.vertex_index = INDEX_W'(i);
      end
    end
    if (hit) begin
      r.status = STATUS_FOUND;
    end else if (welded_count < TABLE_DEPTH) begin
      welded_keys[welded_count] = k;
      r.vertex_index = INDEX_W'(welded_count);
      r.status = STATUS_INSERTED;
      welded_count++;
    end
    r.unique_count = COUNT_W'(welded_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] special_coord();
    case ($urandom_range(0, 6))
      0: return PAT_ZERO;
      1: return PAT_ONES;
      2: return PAT_NZERO;
      3: return PAT_INF;
      4: return PAT_QNAN;
      5: return PAT_NINF;
      default: return {61'd0, 3'($urandom_range(0, 7))};   // small integer grid
    endcase
  endfunction

  function automatic logic [63:0] rand_coord();
    if ($urandom_range(0, 15) < 3) return special_coord();
    return {$urandom, $urandom};
  endfunction

  function automatic evd_key_t rand_key();
    evd_key_t k;
    k.x = rand_coord();
    k.y = rand_coord();
    k.z = rand_coord();
    return k;
  endfunction

  function automatic evd_key_t special_key();
    evd_key_t k;
    k.x = special_coord();
    k.y = special_coord();
    k.z = special_coord();
    return k;
  endfunction

  // One flipped bit: must never weld onto the original
  function automatic evd_key_t flip_key_bit(evd_key_t k);
    int b;
    b = $urandom_range(0, 3 * COORD_W - 1);
    k[b] = ~k[b];
    return k;
  endfunction

  function automatic evd_key_t pick_welded();
    return welded_keys[$urandom_range(0, welded_count - 1)];
  endfunction

  // Mostly short gaps, a few long ones; none while a burst is running
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  // --------------------------------------------------------------------------
  // Drive one vertex, hold it until the transfer, then predict and idle.
  // --------------------------------------------------------------------------
  task automatic send_vertex(input bit ms, input evd_key_t k, input bit typed,
                             input evd_out_t want);
    evd_in_t  v;
    evd_in_t  junk;
    evd_out_t p;
    int       gap;
    v.mesh_start   = ms;
    v.coord_x_bits = k.x;
    v.coord_y_bits = k.y;
    v.coord_z_bits = k.z;
    start   <= 1'b1;
    in_item <= v;
    do @(posedge clk); while (busy);
    p = weld_lookup(v);
    pending_welds.insert(pending_welds.size(), typed ? want : p);
    vertices_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      // Drop start and scramble the payload: the block must ignore it
      junk.mesh_start   = 1'($urandom);
      junk.coord_x_bits = {$urandom, $urandom};
      junk.coord_y_bits = {$urandom, $urandom};
      junk.coord_z_bits = {$urandom, $urandom};
      start   <= 1'b0;
      in_item <= junk;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input bit ms, input evd_key_t k);
    send_vertex(ms, k, 1'b0, '0);
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain_welds();
    start <= 1'b0;
    do @(posedge clk); while (pending_welds.size() != 0);
  endtask

  task automatic add_row(input bit ms, input logic [63:0] x, input logic [63:0] y,
                         input logic [63:0] z, input bit typed,
                         input int idx, input logic [STATUS_W-1:0] st, input int cnt);
    weld_row_t row;
    row.mesh_start = ms;
    row.key.x = x;
    row.key.y = y;
    row.key.z = z;
    row.typed = typed;
    row.want.vertex_index = INDEX_W'(idx);
    row.want.status = st;
    row.want.unique_count = COUNT_W'(cnt);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Triangles with shared corners, near misses and the odd stray restart
  task automatic small_mesh();
    int       tris;
    int       r;
    bit       carry_on;
    bit       ms;
    evd_key_t k;
    no_idle = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 7) == 0) drain_welds();
    tris = $urandom_range(1, 16);
    // Occasionally keep welding into the previous mesh (only when it is small)
    carry_on = (welded_count < 64) && ($urandom_range(0, 19) == 0);
    for (int t = 0; t < tris; t++) begin
      for (int c = 0; c < 3; c++) begin
        ms = ((t == 0) && (c == 0) && !carry_on) || ($urandom_range(0, 49) == 0);
        r = $urandom_range(0, 99);
        if (welded_count > 0 && r < 40) k = pick_welded();
        else if (welded_count > 0 && r < 50) k = flip_key_bit(pick_welded());
        else if (r < 56) k = special_key();
        else k = rand_key();
        send_random(ms, k);
      end
    end
  endtask

  // Weld unique vertices until the table is full, then probe it while full
  task automatic fill_table();
    int r;
    no_idle = 1'b0;
    send_random(1'b1, rand_key());
    while (welded_count < TABLE_DEPTH) begin
      r = $urandom_range(0, 99);
      if (r < 92) send_random(1'b0, rand_key());
      else if (r < 97) send_random(1'b0, pick_welded());
      else send_random(1'b0, flip_key_bit(pick_welded()));
    end
    send_random(1'b0, welded_keys[TABLE_DEPTH - 1]);
    send_random(1'b0, welded_keys[0]);
    send_random(1'b0, flip_key_bit(welded_keys[TABLE_DEPTH - 1]));
    for (int n = 0; n < 30; n++) begin
      if ($urandom_range(0, 1) == 0) send_random(1'b0, rand_key());
      else send_random(1'b0, pick_welded());
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker: one transfer per strobe, matched against the oldest
  // expectation.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input evd_out_t want,
                                 input evd_out_t got);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t: %s: expected idx=%0d status=%0d count=%0d, got idx=%0d status=%0d count=%0d",
               $realtime, what, want.vertex_index, want.status, want.unique_count,
               got.vertex_index, got.status, got.unique_count);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : weld_checker
    evd_out_t want;
    if (rst_n && out_valid) begin
      if (pending_welds.size() == 0) begin
        report_mismatch("unexpected result", '0, out_item);
      end else begin
        want = pending_welds.pop_front();
        if (out_item.vertex_index !== want.vertex_index ||
            out_item.status !== want.status ||
            out_item.unique_count !== want.unique_count) begin
          report_mismatch("result mismatch", want, out_item);
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit big_done;
    welded_count  = 0;
    vertices_sent = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    no_idle       = 1'b0;
    big_done      = 1'b0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;

    // Directed rows: typed expectations where the answer is obvious
    add_row(0, PAT_ZERO,  PAT_ZERO,  PAT_ZERO,  1, 0, STATUS_INSERTED, 1);
    add_row(0, PAT_ZERO,  PAT_ZERO,  PAT_ZERO,  1, 0, STATUS_FOUND,    1);
    add_row(0, PAT_ONES,  PAT_ONES,  PAT_ONES,  1, 1, STATUS_INSERTED, 2);
    add_row(0, PAT_ONES,  PAT_ONES,  PAT_ONES,  1, 1, STATUS_FOUND,    2);
    // +0.0 and -0.0 are different keys
    add_row(0, PAT_ZERO,  PAT_ZERO,  PAT_NZERO, 1, 2, STATUS_INSERTED, 3);
    add_row(0, PAT_NZERO, PAT_ZERO,  PAT_ZERO,  1, 3, STATUS_INSERTED, 4);
    // NaNs weld only onto the identical pattern
    add_row(0, PAT_QNAN,  PAT_QNAN,  PAT_QNAN,  1, 4, STATUS_INSERTED, 5);
    add_row(0, PAT_QNAN,  PAT_QNAN,  PAT_QNAN | 64'd1, 1, 5, STATUS_INSERTED, 6);
    add_row(0, PAT_QNAN,  PAT_QNAN,  PAT_QNAN,  1, 4, STATUS_FOUND,    6);
    add_row(0, PAT_ONES,  PAT_ONES,  PAT_ONES ^ 64'd1, 1, 6, STATUS_INSERTED, 7);
    add_row(0, PAT_NZERO, PAT_ZERO,  PAT_ZERO,  1, 3, STATUS_FOUND,    7);
    add_row(0, PAT_ZERO,  PAT_NZERO, PAT_ZERO,  1, 7, STATUS_INSERTED, 8);
    add_row(0, PAT_ALT_A, PAT_ALT_5, PAT_ALT_A, 0, 0, STATUS_FOUND,    0);
    add_row(0, PAT_ALT_5, PAT_ALT_A, PAT_ALT_5, 0, 0, STATUS_FOUND,    0);
    add_row(0, PAT_ALT_A, PAT_ALT_5, PAT_ALT_A, 0, 0, STATUS_FOUND,    0);
    // Mesh start empties the table, so the vertex always lands at index 0
    add_row(1, PAT_ONES,  PAT_ONES,  PAT_ONES,  1, 0, STATUS_INSERTED, 1);
    add_row(0, PAT_ZERO,  PAT_ZERO,  PAT_ZERO,  1, 1, STATUS_INSERTED, 2);
    add_row(0, PAT_ONES,  PAT_ONES,  PAT_ONES,  1, 0, STATUS_FOUND,    2);
    add_row(1, PAT_ONES,  PAT_ONES,  PAT_ONES,  1, 0, STATUS_INSERTED, 1);
    add_row(1, PAT_ZERO,  PAT_ZERO,  PAT_ZERO,  1, 0, STATUS_INSERTED, 1);
    add_row(0, PAT_INF,   PAT_NINF,  PAT_ZERO,  0, 0, STATUS_FOUND,    0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_vertex(directed_rows[i].mesh_start, directed_rows[i].key,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // Random meshes, with one capacity run part way through
    while (vertices_sent < TOTAL_ITEMS) begin
      if (!big_done && vertices_sent >= SMALL_PHASE) begin
        drain_welds();
        fill_table();
        big_done = 1'b1;
      end else begin
        small_mesh();
      end
    end

    // Wait out the last results, then allow time for anything stray
    start <= 1'b0;
    do @(posedge clk); while (pending_welds.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_welds.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
